// ----- hdl/wfp_pkg.sv -----
// Shared types, codes and arithmetic helpers of the world-to-Frenet projection unit.
`timescale 1ns / 1ps
`default_nettype none
package wfp_pkg;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // Horner coefficients of the quarter-wave sine, Q30, highest power first
   localparam logic signed [33:0] SINE_SEED = -34'sd3864;
   localparam logic signed [31:0] SINE_COEF [5] = '{
      32'sd172272, -32'sd5026995, 32'sd85569305, -32'sd693598668, 32'sd1686629713
   };
   localparam logic signed [37:0] Q30_ONE = 38'sd1073741824;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [15:0]        heading;
      logic [30:0]        arc;
   } entry_type;

   typedef struct packed {
      logic               start;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic [15:0]        heading;
      logic [30:0]        arc;
   } xf_req_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] s;
      logic signed [31:0] d;
   } xf_rsp_type;

   // divide by 2^30, round to nearest, halves away from zero
   function automatic logic signed [37:0] round_q30(input logic signed [67:0] v);
      logic [67:0] mg;
      logic [67:0] t;
      mg = v[67] ? 68'(-v) : 68'(v);
      t  = (mg + 68'd536870912) >> 30;
      return v[67] ? $signed(-t[37:0]) : $signed(t[37:0]);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      if (v > 40'sd2147483647) return 32'sh7fffffff;
      if (v < -40'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

endpackage
`default_nettype wire

// ----- hdl/wfp_req_if.sv -----
// Request channel of the world-to-Frenet projection unit.
`timescale 1ns / 1ps
`default_nettype none
interface wfp_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic [15:0]        point_heading;
   logic [30:0]        point_arc;
   modport source (output valid, command, pos_x, pos_y, point_heading, point_arc,
                   input ready);
   modport sink (input valid, command, pos_x, pos_y, point_heading, point_arc,
                 output ready);
endinterface
`default_nettype wire

// ----- hdl/wfp_rsp_if.sv -----
// Response channel of the world-to-Frenet projection unit.
`timescale 1ns / 1ps
`default_nettype none
interface wfp_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] frenet_s;
   logic signed [31:0] frenet_d;
   logic [9:0]         nearest_index;
   modport source (output valid, status, frenet_s, frenet_d, nearest_index, input ready);
   modport sink (input valid, status, frenet_s, frenet_d, nearest_index, output ready);
endinterface
`default_nettype wire

// ----- hdl/world_to_frenet_projection_unit.sv -----
// Top level: reference line memory, nearest-entry scan and response register.
//
// Keeps up to POINTS reference entries in one synchronous memory. Clear and append
// are answered from the idle state. A query scans entries 0..count-1 through the
// memory's read port, one entry per cycle through a four-stage distance pipeline,
// then rereads the nearest entry and runs the shared-multiplier sine/cosine and
// rotation sequencer. A response waits in an output register; the next request is
// accepted once that response is taken, in the same cycle at the earliest.
`timescale 1ns / 1ps
`default_nettype none
module world_to_frenet_projection_unit #(
   parameter int POINTS = 1024
) (
   input  logic       clock,
   input  logic       reset,
   wfp_req_if.sink    req,
   wfp_rsp_if.source  rsp
);
   import wfp_pkg::*;

   localparam int IW = (POINTS > 1) ? $clog2(POINTS) : 1;
   localparam int CW = $clog2(POINTS + 1);

   typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_FETCH, ST_LOAD, ST_CALC, ST_HOLD}
      state_type;

   entry_type          line_mem [POINTS];
   entry_type          rd_data_ff;
   logic [IW-1:0]      rd_addr;

   state_type          state_ff;
   logic [CW-1:0]      count_ff, issue_ff;
   logic signed [31:0] qx_ff, qy_ff;
   logic               p1_v_ff, p2_v_ff, p3_v_ff;
   logic [IW-1:0]      p1_idx_ff, p2_idx_ff, p3_idx_ff, best_ff;
   logic [32:0]        ax_ff, ay_ff;
   logic [63:0]        a2_ff, b2_ff, best_d_ff;

   logic               rsp_valid_ff;
   logic [1:0]         status_ff;
   logic signed [31:0] s_ff, d_ff;
   logic [9:0]         index_ff;

   logic               accept, slot_free;
   logic signed [32:0] dx_c, dy_c;
   logic [64:0]        sum_c;
   logic [63:0]        dist_c;
   logic [65:0]        sq_x, sq_y;
   logic [IW+9:0]      best_ext;
   xf_req_type         xf_req;
   xf_rsp_type         xf_rsp;

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE) && slot_free;
   assign accept    = req.valid && req.ready;

   always_comb begin
      rd_addr = (state_ff == ST_SCAN) ? issue_ff[IW-1:0] : best_ff;
      dx_c    = 33'(qx_ff) - 33'(rd_data_ff.x);
      dy_c    = 33'(qy_ff) - 33'(rd_data_ff.y);
      sq_x    = ax_ff * ax_ff;
      sq_y    = ay_ff * ay_ff;
      sum_c   = {1'b0, a2_ff} + {1'b0, b2_ff};
      dist_c  = sum_c[64] ? '1 : sum_c[63:0];
      best_ext = {10'b0, best_ff};
      xf_req  = '{start: state_ff == ST_LOAD, dx: dx_c, dy: dy_c,
                  heading: rd_data_ff.heading, arc: rd_data_ff.arc};
   end

   always_ff @(posedge clock) begin
      if (accept && req.command == CMD_APPEND && count_ff < CW'(POINTS))
         line_mem[count_ff[IW-1:0]] <= '{x: req.pos_x, y: req.pos_y,
                                          heading: req.point_heading, arc: req.point_arc};
      rd_data_ff <= line_mem[rd_addr];
   end

   wfp_transform u_transform (
      .clock  (clock),
      .reset  (reset),
      .xf_req (xf_req),
      .xf_rsp (xf_rsp)
   );

   always_ff @(posedge clock) begin
      ax_ff <= dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
      ay_ff <= dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
      a2_ff <= sq_x[63:0];
      b2_ff <= sq_y[63:0];
      p2_idx_ff <= p1_idx_ff;
      p3_idx_ff <= p2_idx_ff;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         p1_v_ff      <= 1'b0;
         p2_v_ff      <= 1'b0;
         p3_v_ff      <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         p1_v_ff <= 1'b0;
         p2_v_ff <= p1_v_ff;
         p3_v_ff <= p2_v_ff;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  status_ff <= STATUS_OK;
                  s_ff      <= '0;
                  d_ff      <= '0;
                  index_ff  <= '0;
                  qx_ff     <= req.pos_x;
                  qy_ff     <= req.pos_y;
                  issue_ff  <= '0;
                  case (req.command)
                     CMD_CLEAR: begin
                        count_ff     <= '0;
                        rsp_valid_ff <= 1'b1;
                     end
                     CMD_APPEND: begin
                        if (count_ff < CW'(POINTS)) count_ff <= count_ff + 1'b1;
                        else status_ff <= STATUS_FULL;
                        rsp_valid_ff <= 1'b1;
                     end
                     CMD_QUERY: begin
                        if (count_ff == '0) begin
                           status_ff    <= STATUS_EMPTY;
                           rsp_valid_ff <= 1'b1;
                        end else begin
                           state_ff <= ST_SCAN;
                        end
                     end
                     default: rsp_valid_ff <= 1'b1;
                  endcase
               end
            end
            ST_SCAN: begin
               if (issue_ff != count_ff) begin
                  p1_v_ff   <= 1'b1;
                  p1_idx_ff <= issue_ff[IW-1:0];
                  issue_ff  <= issue_ff + 1'b1;
               end else if (!p1_v_ff && !p2_v_ff && !p3_v_ff) begin
                  state_ff <= ST_FETCH;
               end
               if (p3_v_ff && (p3_idx_ff == '0 || dist_c < best_d_ff)) begin
                  best_d_ff <= dist_c;
                  best_ff   <= p3_idx_ff;
               end
            end
            ST_FETCH: state_ff <= ST_LOAD;
            ST_LOAD:  state_ff <= ST_CALC;
            ST_CALC: begin
               if (xf_rsp.done) begin
                  s_ff     <= xf_rsp.s;
                  d_ff     <= xf_rsp.d;
                  index_ff <= best_ext[9:0];
                  state_ff <= ST_HOLD;
               end
            end
            ST_HOLD: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = status_ff;
   assign rsp.frenet_s      = s_ff;
   assign rsp.frenet_d      = d_ff;
   assign rsp.nearest_index = index_ff;

endmodule
`default_nettype wire

// ----- hdl/wfp_transform.sv -----
// Sine/cosine evaluation and rotation of the offset into along and cross distances.
`timescale 1ns / 1ps
`default_nettype none
module wfp_transform (
   input  logic                clock,
   input  logic                reset,
   input  wfp_pkg::xf_req_type xf_req,
   output wfp_pkg::xf_rsp_type xf_rsp
);
   import wfp_pkg::*;

   typedef enum logic [2:0] {XF_IDLE, XF_SIN_MUL, XF_SIN_ACC, XF_ROT_MUL, XF_ROT_ACC}
      xf_state_type;

   xf_state_type       state_ff;
   logic [2:0]         step_ff;
   logic               pass_ff;
   logic signed [32:0] dx_ff, dy_ff;
   logic [15:0]        heading_ff;
   logic [30:0]        arc_ff;
   logic signed [33:0] u2_ff, p_ff, sin_ff, cos_ff;
   logic signed [67:0] prod_ff, acc_ff;
   logic               done_ff;
   logic signed [31:0] s_ff, d_ff;

   logic [15:0]        ang;
   logic [14:0]        rr;
   logic signed [33:0] u_c, mul_a, mul_b;
   logic signed [67:0] prod_in, rnd_in;
   logic signed [37:0] rnd, qs;
   logic signed [33:0] trig;

   always_comb begin
      ang = pass_ff ? 16'(heading_ff + 16'd16384) : heading_ff;
      rr  = ang[14] ? 15'(15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
      u_c = {3'b000, rr, 16'b0};
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         XF_SIN_MUL: begin
            if (step_ff == 3'd0) begin
               mul_a = u_c;
               mul_b = u_c;
            end else if (step_ff == 3'd6) begin
               mul_a = p_ff;
               mul_b = u_c;
            end else begin
               mul_a = p_ff;
               mul_b = u2_ff;
            end
         end
         XF_ROT_MUL: begin
            case (step_ff[1:0])
               2'd0: begin mul_a = 34'(dx_ff); mul_b = cos_ff; end
               2'd1: begin mul_a = 34'(dy_ff); mul_b = sin_ff; end
               2'd2: begin mul_a = 34'(dy_ff); mul_b = cos_ff; end
               default: begin mul_a = 34'(dx_ff); mul_b = sin_ff; end
            endcase
         end
         default: ;
      endcase
      prod_in = mul_a * mul_b;
      if (state_ff == XF_ROT_ACC && step_ff[1:0] == 2'd1) rnd_in = acc_ff + prod_ff;
      else if (state_ff == XF_ROT_ACC && step_ff[1:0] == 2'd3) rnd_in = acc_ff - prod_ff;
      else rnd_in = prod_ff;
      rnd = round_q30(rnd_in);
      if (rnd[37]) qs = '0;
      else if (rnd > Q30_ONE) qs = Q30_ONE;
      else qs = rnd;
      trig = ang[15] ? 34'(-qs) : 34'(qs);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      done_ff <= 1'b0;
      if (reset) begin
         state_ff <= XF_IDLE;
         done_ff  <= 1'b0;
      end else begin
         case (state_ff)
            XF_IDLE: begin
               if (xf_req.start) begin
                  dx_ff      <= xf_req.dx;
                  dy_ff      <= xf_req.dy;
                  heading_ff <= xf_req.heading;
                  arc_ff     <= xf_req.arc;
                  pass_ff    <= 1'b0;
                  step_ff    <= '0;
                  state_ff   <= XF_SIN_MUL;
               end
            end
            XF_SIN_MUL: state_ff <= XF_SIN_ACC;
            XF_SIN_ACC: begin
               state_ff <= XF_SIN_MUL;
               step_ff  <= step_ff + 3'd1;
               if (step_ff == 3'd0) begin
                  u2_ff <= rnd[33:0];
                  p_ff  <= SINE_SEED;
               end else if (step_ff == 3'd6) begin
                  step_ff <= '0;
                  if (pass_ff) begin
                     cos_ff   <= trig;
                     state_ff <= XF_ROT_MUL;
                  end else begin
                     sin_ff  <= trig;
                     pass_ff <= 1'b1;
                  end
               end else begin
                  p_ff <= 34'(SINE_COEF[step_ff - 3'd1]) + rnd[33:0];
               end
            end
            XF_ROT_MUL: state_ff <= XF_ROT_ACC;
            XF_ROT_ACC: begin
               state_ff <= XF_ROT_MUL;
               step_ff  <= step_ff + 3'd1;
               case (step_ff[1:0])
                  2'd0, 2'd2: acc_ff <= prod_ff;
                  2'd1: s_ff <= sat32($signed({9'b0, arc_ff}) + 40'(rnd));
                  default: begin
                     d_ff     <= sat32(40'(rnd));
                     done_ff  <= 1'b1;
                     state_ff <= XF_IDLE;
                  end
               endcase
            end
            default: state_ff <= XF_IDLE;
         endcase
      end
   end

   assign xf_rsp = '{done: done_ff, s: s_ff, d: d_ff};

endmodule
`default_nettype wire

// ----- verif/world_to_frenet_projection_unit_tb.sv -----
// Testbench of the world-to-Frenet projection unit: directed table and random requests.
`timescale 1ns / 1ps
module world_to_frenet_projection_unit_tb;
   import wfp_pkg::*;

   localparam int POINTS = 1024;

   typedef struct {
      logic [1:0]         command;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [15:0]        heading;
      logic [30:0]        arc;
      bit                 typed;
      logic [1:0]         status;
      logic signed [31:0] s;
      logic signed [31:0] d;
      logic [9:0]         index;
   } row_type;

   typedef struct {
      logic [1:0]         status;
      logic signed [31:0] s;
      logic signed [31:0] d;
      logic [9:0]         index;
   } proj_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wfp_req_if req_ch ();
   wfp_rsp_if rsp_ch ();

   world_to_frenet_projection_unit #(.POINTS(POINTS)) DUT (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source)
   );

   always #5 clock = ~clock;

   logic signed [31:0] line_x     [POINTS];
   logic signed [31:0] line_y     [POINTS];
   logic [15:0]        line_hd    [POINTS];
   logic [30:0]        line_arc   [POINTS];
   int                 line_count;

   proj_type expected_q [$];
   int mismatches;
   int results_seen;
   int queries_sent;
   int send_idle_pct;
   int recv_stall_pct;

   function automatic longint div_q30(longint v);
      if (v >= 0) return (v + 64'sd536870912) >>> 30;
      return -((-v + 64'sd536870912) >>> 30);
   endfunction

   function automatic longint quarter_wave(int unsigned r);
      longint u, u2, p;
      if (r == 0) return 0;
      u  = longint'(r) <<< 16;
      u2 = div_q30(u * u);
      p  = -3864;
      p  = 172272 + div_q30(p * u2);
      p  = -5026995 + div_q30(p * u2);
      p  = 85569305 + div_q30(p * u2);
      p  = -693598668 + div_q30(p * u2);
      p  = 1686629713 + div_q30(p * u2);
      p  = div_q30(p * u);
      if (p < 0) p = 0;
      if (p > 64'sd1073741824) p = 64'sd1073741824;
      return p;
   endfunction

   function automatic longint angle_sine(logic [15:0] h);
      int unsigned r;
      r = h[13:0];
      case (h[15:14])
         2'd0: return quarter_wave(r);
         2'd1: return quarter_wave(16384 - r);
         2'd2: return -quarter_wave(r);
         default: return -quarter_wave(16384 - r);
      endcase
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // squared distance with saturation at 2^64-1
   function automatic logic [63:0] dist_sq(longint dx, longint dy);
      logic [63:0] ax, ay, a2, b2;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      a2 = ax * ax;
      b2 = ay * ay;
      if (a2 > 64'hffff_ffff_ffff_ffff - b2) return 64'hffff_ffff_ffff_ffff;
      return a2 + b2;
   endfunction

   function automatic proj_type project_request(logic [1:0] cmd, logic signed [31:0] px,
                                                logic signed [31:0] py, logic [15:0] hd,
                                                logic [30:0] arc);
      proj_type    r;
      int          best;
      logic [63:0] best_d, dd;
      longint      dx, dy, sn, cs;
      r = '{STATUS_OK, 0, 0, 0};
      if (cmd == CMD_CLEAR) begin
         line_count = 0;
      end else if (cmd == CMD_APPEND) begin
         if (line_count >= POINTS) begin
            r.status = STATUS_FULL;
         end else begin
            line_x[line_count]   = px;
            line_y[line_count]   = py;
            line_hd[line_count]  = hd;
            line_arc[line_count] = arc;
            line_count++;
         end
      end else if (cmd == CMD_QUERY) begin
         if (line_count == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            best = 0;
            best_d = 0;
            for (int i = 0; i < line_count; i++) begin
               dd = dist_sq(longint'(px) - longint'(line_x[i]),
                            longint'(py) - longint'(line_y[i]));
               if (i == 0 || dd < best_d) begin
                  best_d = dd;
                  best = i;
               end
            end
            dx = longint'(px) - longint'(line_x[best]);
            dy = longint'(py) - longint'(line_y[best]);
            sn = angle_sine(line_hd[best]);
            cs = angle_sine(line_hd[best] + 16'd16384);
            r.s = clamp32(longint'({1'b0, line_arc[best]}) + div_q30(dx * cs + dy * sn));
            r.d = clamp32(div_q30(dy * cs - dx * sn));
            r.index = best[9:0];
         end
      end
      return r;
   endfunction

   task automatic send_request(logic [1:0] cmd, logic signed [31:0] px,
                               logic signed [31:0] py, logic [15:0] hd, logic [30:0] arc,
                               bit typed, proj_type want);
      proj_type p;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.command       <= cmd;
      req_ch.pos_x         <= px;
      req_ch.pos_y         <= py;
      req_ch.point_heading <= hd;
      req_ch.point_arc     <= arc;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      p = project_request(cmd, px, py, hd, arc);
      if (typed && p != want)
         $display("note: typed row differs from prediction, cmd %0d", cmd);
      expected_q.insert(expected_q.size(), typed ? want : p);
      if (cmd == CMD_QUERY) queries_sent++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $urandom;
         default: return $signed(32'($urandom_range(4000000))) - 32'sd2000000;
      endcase
   endfunction

   // receiver
   always @(negedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      proj_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response at %0t", $realtime);
         end else begin
            want = expected_q.pop_front();
            if (rsp_ch.status !== want.status || rsp_ch.frenet_s !== want.s ||
                rsp_ch.frenet_d !== want.d || rsp_ch.nearest_index !== want.index) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp st %0d s %0d d %0d idx %0d, got st %0d s %0d d %0d idx %0d",
                           want.status, want.s, want.d, want.index, rsp_ch.status,
                           rsp_ch.frenet_s, rsp_ch.frenet_d, rsp_ch.nearest_index);
            end
         end
      end
   end

   row_type directed [18] = '{
      '{CMD_QUERY, 0, 0, 0, 0, 1, STATUS_EMPTY, 0, 0, 0},
      '{CMD_APPEND, 0, 0, 0, 0, 1, STATUS_OK, 0, 0, 0},
      '{CMD_QUERY, 32'sh10000, 0, 0, 0, 1, STATUS_OK, 32'sh10000, 0, 0},
      '{CMD_QUERY, 0, 32'sh10000, 0, 0, 1, STATUS_OK, 0, 32'sh10000, 0},
      '{CMD_APPEND, 32'sh7fffffff, 32'sh7fffffff, 16'h4000, 31'h7fffffff, 1, STATUS_OK, 0, 0, 0},
      '{CMD_APPEND, 32'sh80000000, 32'sh80000000, 16'hffff, 31'd100, 1, STATUS_OK, 0, 0, 0},
      '{CMD_APPEND, 0, 0, 16'h8000, 31'd5, 1, STATUS_OK, 0, 0, 0},
      '{CMD_QUERY, 32'sh7fffffff, 32'sh80000000, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_QUERY, 32'sh80000000, 32'sh7fffffff, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_QUERY, 32'sh7fff0000, 32'sh7fff0000, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_QUERY, 32'sh80001000, 32'sh80000000, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{2'd3, 32'sh7fffffff, 32'sh80000000, 16'hffff, 31'h7fffffff, 1, STATUS_OK, 0, 0, 0},
      '{CMD_APPEND, 32'sh12345, -32'sh23456, 16'h2000, 31'h4000_0000, 0, 0, 0, 0, 0},
      '{CMD_APPEND, 32'sh12345, -32'sh23456, 16'hc000, 31'h0, 0, 0, 0, 0, 0},
      '{CMD_QUERY, 32'sh12345, -32'sh13456, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_CLEAR, 32'sh7fffffff, 32'sh7fffffff, 16'hffff, 31'h7fffffff, 1, STATUS_OK, 0, 0, 0},
      '{CMD_QUERY, 0, 0, 0, 0, 1, STATUS_EMPTY, 0, 0, 0}
   };

   initial begin
      proj_type want;
      int       phase_len;
      req_ch.valid = 1'b0;
      req_ch.command = CMD_CLEAR;
      req_ch.pos_x = 0;
      req_ch.pos_y = 0;
      req_ch.point_heading = 0;
      req_ch.point_arc = 0;
      line_count = 0;
      mismatches = 0;
      results_seen = 0;
      queries_sent = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         want = '{directed[i].status, directed[i].s, directed[i].d, directed[i].index};
         send_request(directed[i].command, directed[i].pos_x, directed[i].pos_y,
                      directed[i].heading, directed[i].arc, directed[i].typed, want);
      end
      drain_results();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 65 : 22) : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 65 : 22) : 0;
         phase_len = 139;
         send_request(CMD_CLEAR, 0, 0, 0, 0, 0, want);
         for (int n = 0; n < phase_len; n++) begin
            case ($urandom_range(9))
               0: send_request(CMD_CLEAR, $urandom, $urandom, 16'($urandom), 31'($urandom),
                               0, want);
               1, 2, 3, 4: send_request(CMD_APPEND, rand_coord(), rand_coord(),
                                        16'($urandom), 31'($urandom), 0, want);
               5: send_request(2'd3, $urandom, $urandom, 16'($urandom), 31'($urandom),
                               0, want);
               default: send_request(CMD_QUERY, rand_coord(), rand_coord(),
                                     16'($urandom), 31'($urandom), 0, want);
            endcase
            if (n == 70) drain_results();
         end
      end
      drain_results();
      $display("Covered %0d responses (%0d queries), empty table, four idle mixes.",
               results_seen, queries_sent);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatches, expected_q.size());
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #200ms;
      $display("timeout");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
